>>> hw/rtl/max_empty_rectangle_area_macros.svh
// Assertion macros used by the RTL of the max empty rectangle block.
`ifndef MAX_EMPTY_RECTANGLE_AREA_MACROS_SVH
`define MAX_EMPTY_RECTANGLE_AREA_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MERA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MERA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/mera_pkg.sv
// Shared constants and types of the max empty rectangle block.
package mera_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int CFG_W    = 11;
   localparam int HGT_W    = $clog2(MAX_ROWS + 1);
   localparam int AREA_W   = 21;
   localparam int PROD_W   = 2 * HGT_W;
   localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

   // One stack entry: bar height and leftmost column it extends to.
   typedef struct packed {
      logic [HGT_W-1:0] hgt;
      logic [COL_W-1:0] start;
   } stk_entry_type;

endpackage

>>> hw/rtl/mera_ram.sv
// Generic simple dual-port RAM with registered read.
module mera_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/max_empty_rectangle_area.sv
// Largest all-free rectangle in a raster-ordered binary grid, one cell per transaction.
// A cell steps through accept with height read, height write-back and stack push, with a
// pop step for each column it pops off the monotonic stack and a reload step for each
// stack reload from memory; the cell that ends a row adds a flush pass that pops every
// remaining stack entry the same way, plus a final step that closes the row. The stack and
// the column heights live in two RAMs with one read port each, which sets this sequence of
// steps. The cell with tlast then loads the result register once the previous result, if
// any, has been taken. After reset and after every transaction with tlast, a clearing pass
// writes zero to all 1024 height entries, one per cycle, during which no cell is taken;
// csr writes are taken at any time. The result leaves through an output register, so the
// next grid can start while it waits.
module max_empty_rectangle_area (
   input  logic        clock,
   input  logic        reset,
   // configuration: columns per row
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data,
   // cells
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] occupied, [7:1] zero
   input  logic        req_tlast,   // last cell of the grid
   // result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [20:0] max_area, [23:21] zero
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_POP   = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam int COL_W  = mera_pkg::COL_W;
   localparam int HGT_W  = mera_pkg::HGT_W;
   localparam int CFG_W  = mera_pkg::CFG_W;
   localparam int AREA_W = mera_pkg::AREA_W;
   localparam int PROD_W = mera_pkg::PROD_W;

   logic [2:0]              state_ff, state_in;
   logic [CFG_W-1:0]        cols_ff, cols_in;
   logic [COL_W-1:0]        clr_ff, clr_in;
   logic [COL_W-1:0]        pos_ff, pos_in;
   logic                    occ_ff, occ_in;
   logic                    last_ff, last_in;
   logic                    row_end_ff, row_end_in;
   logic                    flush_ff, flush_in;
   logic [HGT_W-1:0]        cur_h_ff, cur_h_in;
   logic [CFG_W-1:0]        cur_i_ff, cur_i_in;
   logic [COL_W-1:0]        start_ff, start_in;
   mera_pkg::stk_entry_type top_ff, top_in;
   logic                    top_valid_ff, top_valid_in;
   logic [COL_W-1:0]        sp_ff, sp_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    prod_valid_ff, prod_valid_in;
   logic [AREA_W-1:0]       best_ff, best_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]       rsp_area_ff, rsp_area_in;

   logic                    req_fire;
   logic [CFG_W-1:0]        cols_eff;
   logic [CFG_W-1:0]        pos_next;
   logic [HGT_W-1:0]        hgt_rd;
   logic [HGT_W-1:0]        hgt_new;
   logic                    hgt_we;
   logic [COL_W-1:0]        hgt_waddr;
   logic [HGT_W-1:0]        hgt_wdata;
   logic                    stk_we;
   logic                    stk_re;
   mera_pkg::stk_entry_type stk_rd;
   logic                    do_pop;
   logic [CFG_W-1:0]        span;
   logic [AREA_W-1:0]       prod_sat;
   logic                    stk_empty;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24 - AREA_W){1'b0}}, rsp_area_ff};

   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = CFG_W'(1);
      end else if (cols_ff > CFG_W'(mera_pkg::MAX_COLS)) begin
         cols_eff = CFG_W'(mera_pkg::MAX_COLS);
      end else begin
         cols_eff = cols_ff;
      end
   end

   assign pos_next = {1'b0, pos_ff} + CFG_W'(1);

   // saturating run-height update
   always_comb begin
      if (occ_ff) begin
         hgt_new = '0;
      end else if (hgt_rd < HGT_W'(mera_pkg::MAX_ROWS)) begin
         hgt_new = hgt_rd + HGT_W'(1);
      end else begin
         hgt_new = hgt_rd;
      end
   end

   assign hgt_we    = (state_ff == S_CLEAR) || (state_ff == S_READ);
   assign hgt_waddr = (state_ff == S_CLEAR) ? clr_ff : pos_ff;
   assign hgt_wdata = (state_ff == S_CLEAR) ? '0 : hgt_new;

   // Heights are read on accept and written back in the following cycle; the next read
   // cannot issue before that write, so no forwarding is needed.
   mera_ram #(
      .WIDTH (HGT_W),
      .DEPTH (mera_pkg::MAX_COLS)
   ) u_hgt_ram (
      .clock   (clock),
      .wr_en   (hgt_we),
      .wr_addr (hgt_waddr),
      .wr_data (hgt_wdata),
      .rd_en   (req_fire),
      .rd_addr (pos_ff),
      .rd_data (hgt_rd)
   );

   assign do_pop = (state_ff == S_POP) && top_valid_ff && (top_ff.hgt >= cur_h_ff);
   assign span   = cur_i_ff - {1'b0, top_ff.start};
   assign stk_re = do_pop && (sp_ff != '0);
   assign stk_we = (state_ff == S_POP) && !do_pop && !flush_ff && top_valid_ff;

   // entries below the cached top of stack
   mera_ram #(
      .WIDTH ($bits(mera_pkg::stk_entry_type)),
      .DEPTH (mera_pkg::MAX_COLS)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff),
      .wr_data (top_ff),
      .rd_en   (stk_re),
      .rd_addr (sp_ff - COL_W'(1)),
      .rd_data (stk_rd)
   );

   assign prod_sat = (prod_ff > PROD_W'(mera_pkg::AREA_MAX)) ? mera_pkg::AREA_MAX
                                                               : prod_ff[AREA_W-1:0];

   assign stk_empty = !top_valid_ff && (sp_ff == '0);

   always_comb begin
      state_in      = state_ff;
      cols_in       = cols_ff;
      clr_in        = clr_ff;
      pos_in        = pos_ff;
      occ_in        = occ_ff;
      last_in       = last_ff;
      row_end_in    = row_end_ff;
      flush_in      = flush_ff;
      cur_h_in      = cur_h_ff;
      cur_i_in      = cur_i_ff;
      start_in      = start_ff;
      top_in        = top_ff;
      top_valid_in  = top_valid_ff;
      sp_in         = sp_ff;
      prod_in       = prod_ff;
      prod_valid_in = 1'b0;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_area_in   = rsp_area_ff;

      if (csr_valid && csr_ready) begin
         cols_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (prod_valid_ff && (prod_sat > best_ff)) begin
         best_in = prod_sat;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + COL_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               occ_in     = req_tdata[0];
               last_in    = req_tlast;
               row_end_in = (pos_next >= cols_eff) || req_tlast;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cur_h_in = hgt_new;
            cur_i_in = {1'b0, pos_ff};
            start_in = pos_ff;
            flush_in = 1'b0;
            state_in = S_POP;
         end
         S_POP: begin
            if (do_pop) begin
               prod_in       = PROD_W'(top_ff.hgt) * PROD_W'(span);
               prod_valid_in = 1'b1;
               start_in      = top_ff.start;
               if (sp_ff != '0) begin
                  sp_in    = sp_ff - COL_W'(1);
                  state_in = S_LOAD;
               end else begin
                  top_valid_in = 1'b0;
               end
            end else if (!flush_ff) begin
               top_in.hgt   = cur_h_ff;
               top_in.start = start_ff;
               top_valid_in = 1'b1;
               if (top_valid_ff) begin
                  sp_in = sp_ff + COL_W'(1);
               end
               if (row_end_ff) begin
                  // zero-height sentinel past the row end empties the stack
                  flush_in = 1'b1;
                  cur_h_in = '0;
                  cur_i_in = pos_next;
               end else begin
                  pos_in   = pos_next[COL_W-1:0];
                  state_in = S_IDLE;
               end
            end else begin
               flush_in = 1'b0;
               pos_in   = '0;
               state_in = last_ff ? S_DONE : S_IDLE;
            end
         end
         S_LOAD: begin
            top_in   = stk_rd;
            state_in = S_POP;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = best_ff;
               best_in      = '0;
               clr_in       = '0;
               state_in     = S_CLEAR;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cols_ff       <= CFG_W'(mera_pkg::MAX_COLS);
         clr_ff        <= '0;
         pos_ff        <= '0;
         row_end_ff    <= 1'b0;
         flush_ff      <= 1'b0;
         top_valid_ff  <= 1'b0;
         sp_ff         <= '0;
         prod_valid_ff <= 1'b0;
         best_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cols_ff       <= cols_in;
         clr_ff        <= clr_in;
         pos_ff        <= pos_in;
         row_end_ff    <= row_end_in;
         flush_ff      <= flush_in;
         top_valid_ff  <= top_valid_in;
         sp_ff         <= sp_in;
         prod_valid_ff <= prod_valid_in;
         best_ff       <= best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      occ_ff      <= occ_in;
      last_ff     <= last_in;
      cur_h_ff    <= cur_h_in;
      cur_i_ff    <= cur_i_in;
      start_ff    <= start_in;
      top_ff      <= top_in;
      prod_ff     <= prod_in;
      rsp_area_ff <= rsp_area_in;
   end

`include "max_empty_rectangle_area_macros.svh"

   `MERA_ASSERT_IMP(a_stk_top_cached, clock, reset, sp_ff != '0, top_valid_ff, "top lost")
   `MERA_ASSERT_IMP(a_stk_empty_done, clock, reset, state_ff == S_DONE, stk_empty, "stack left")
   `MERA_ASSERT_NXT(a_accept_reads, clock, reset, req_fire, state_ff == S_READ, "no read")

endmodule

>>> dv/tb_max_empty_rectangle_area.sv
// Self-checking testbench for max_empty_rectangle_area: directed grid table plus random grids.
`timescale 1ns / 1ps

module tb_max_empty_rectangle_area;

   localparam int MAX_COLS = mera_pkg::MAX_COLS;
   localparam int MAX_ROWS = mera_pkg::MAX_ROWS;
   localparam int CFG_W    = mera_pkg::CFG_W;
   localparam int HGT_W    = mera_pkg::HGT_W;
   localparam int AREA_W   = mera_pkg::AREA_W;
   localparam logic [AREA_W-1:0] AREA_MAX = mera_pkg::AREA_MAX;

   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 4096;   // worst row flush of 1024 columns, with margin
   localparam int IDLE_LIMIT    = 40000;
   localparam int SMALL_CELLS   = 420;
   localparam int MIN_GRIDS     = 40;

   typedef struct packed {
      bit              set_cols;   // write columns before this cell
      bit [CFG_W-1:0]  cols;
      bit              occ;
      bit              last;
      bit              typed;      // area below is the known answer
      bit [AREA_W-1:0] area;
   } cell_step_type;

   localparam int DIRECTED_CELLS = 27;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_data   = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;   // [0] occupied, [7:1] zero
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b1;
   logic [23:0]       rsp_tdata;         // [20:0] max_area, [23:21] zero

   // grid model
   logic [CFG_W-1:0]  columns_reg;
   logic [HGT_W-1:0]  run_height [MAX_COLS];
   int unsigned       next_col;
   logic [AREA_W-1:0] best_area;

   logic [AREA_W-1:0] expected_areas [$];
   logic [AREA_W-1:0] want_area;
   int unsigned       mismatches   = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       ready_hold   = 0;
   bit                sender_idles = 1'b1;
   bit                calm         = 1'b0;

   cell_step_type directed [DIRECTED_CELLS] = '{
      // reset width of 1024: one free cell, then one occupied cell
      '{0, 0,    0, 1, 1, 1},
      '{0, 0,    1, 1, 1, 0},
      // last cell closes a partial row: heights 1 1 0 1
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    1, 0, 0, 0},
      '{0, 0,    0, 1, 1, 2},
      // 2 x 2 all free
      '{1, 2,    0, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    0, 1, 1, 4},
      // zero columns act as one: heights 1 2 0 1
      '{1, 0,    0, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    1, 0, 0, 0},
      '{0, 0,    0, 1, 1, 2},
      // all-ones register clamps to the full width
      '{1, 2047, 1, 0, 0, 0},
      '{0, 0,    0, 1, 1, 1},
      // 3 wide, last cell opens a third row
      '{1, 3,    0, 0, 0, 0},
      '{0, 0,    1, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{0, 0,    0, 1, 0, 0},
      // narrowed from 5 to 2 at column 2: that row closes at 3 cells
      '{1, 5,    0, 0, 0, 0},
      '{0, 0,    0, 0, 0, 0},
      '{1, 2,    0, 0, 0, 0},
      '{0, 0,    0, 1, 0, 0}
   };

   max_empty_rectangle_area dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned cols_in_force();
      if (columns_reg == 0) return 1;
      if (columns_reg > MAX_COLS) return MAX_COLS;
      return columns_reg;
   endfunction

   function automatic void clear_grid();
      foreach (run_height[c]) run_height[c] = '0;
      next_col  = 0;
      best_area = '0;
   endfunction

   // Largest rectangle under the histogram of the first width columns.
   function automatic void score_row(input int unsigned width);
      int unsigned     rising [$];   // column indexes, heights non-decreasing
      int unsigned     c, h, top, left;
      longint unsigned area;
      for (c = 0; c <= width; c++) begin
         h = (c < width) ? run_height[c] : 0;
         while (rising.size() > 0 && run_height[rising[$]] >= h) begin
            top  = rising.pop_back();
            left = (rising.size() > 0) ? rising[$] + 1 : 0;
            area = run_height[top];
            area = area * (c - left);
            if (area > AREA_MAX) area = AREA_MAX;
            if (area > best_area) best_area = area[AREA_W-1:0];
         end
         if (c < width) rising.push_back(c);
      end
   endfunction

   // Advance the model by one cell; returns 1 when the cell ends the grid.
   function automatic bit take_cell(input bit occ, input bit last,
                                    output logic [AREA_W-1:0] area);
      int unsigned pos;
      pos = (next_col >= MAX_COLS) ? MAX_COLS - 1 : next_col;
      if (occ) run_height[pos] = '0;
      else if (run_height[pos] < MAX_ROWS) run_height[pos] = run_height[pos] + 1'b1;
      if (pos + 1 >= cols_in_force() || last) begin
         score_row(pos + 1);
         next_col = 0;
      end else begin
         next_col = pos + 1;
      end
      area = best_area;
      if (last) clear_grid();
      return last;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic pause_cells(input int unsigned n);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_cell(input bit occ, input bit last, input bit typed,
                            input logic [AREA_W-1:0] known);
      logic [AREA_W-1:0] area;
      if (sender_idles && !calm && $urandom_range(0, 3) == 0)
         pause_cells($urandom_range(1, 10));
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {7'b0, occ};
      req_tlast  = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (take_cell(occ, last, area)) expected_areas.push_back(typed ? known : area);
   endtask

   // Let every result out and the block finish its row work before a csr write.
   task automatic settle_block();
      pause_cells(1);
      while (expected_areas.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_columns(input logic [CFG_W-1:0] value);
      settle_block();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      columns_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // result sink: ready and stall in random bursts, steady once calm
   always @(negedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= 1'($urandom_range(0, 1));
         ready_hold <= $urandom_range(0, 9);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_areas.size() == 0) begin
            report_mismatch($sformatf("area %0d with no grid pending",
                                      rsp_tdata[AREA_W-1:0]));
         end else begin
            want_area = expected_areas.pop_front();
            if (rsp_tdata[AREA_W-1:0] !== want_area)
               report_mismatch($sformatf("max_area %0d, expected %0d",
                                         rsp_tdata[AREA_W-1:0], want_area));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("max_empty_rectangle_area regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned small_cells, grids, rows, eff, cells, pct, k, flip_at;
      small_cells = 0;
      grids       = 0;
      columns_reg = 11'd1024;
      clear_grid();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < DIRECTED_CELLS; k++) begin
         if (directed[k].set_cols) write_columns(directed[k].cols);
         send_cell(directed[k].occ, directed[k].last, directed[k].typed, directed[k].area);
      end

      while (small_cells < SMALL_CELLS || grids < MIN_GRIDS) begin
         calm         = (small_cells >= SMALL_CELLS - 70);
         sender_idles = ($urandom_range(0, 2) != 0);
         if (grids == 0 || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0:       write_columns(CFG_W'(0));
               1:       write_columns(CFG_W'(11'h7FF));
               2:       write_columns(CFG_W'($urandom_range(7, 2047)));
               default: write_columns(CFG_W'($urandom_range(1, 6)));
            endcase
         end
         eff   = cols_in_force();
         rows  = $urandom_range(1, 6);
         cells = (eff > 16) ? $urandom_range(1, 24) : rows * eff;
         if (cells > 1 && $urandom_range(0, 3) == 0) cells = $urandom_range(1, cells - 1);
         case ($urandom_range(0, 4))
            0:       pct = 0;
            1:       pct = 15;
            2:       pct = 40;
            3:       pct = 75;
            default: pct = 100;
         endcase
         flip_at = 0;
         if (cells > 1 && $urandom_range(0, 9) == 0) flip_at = $urandom_range(1, cells - 1);
         for (k = 0; k < cells; k++) begin
            if (flip_at != 0 && k == flip_at) write_columns(CFG_W'($urandom_range(1, 6)));
            send_cell($urandom_range(0, 99) < pct, k == cells - 1, 1'b0, '0);
            small_cells++;
         end
         grids++;
      end

      pause_cells(1);
      while (expected_areas.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("max_empty_rectangle_area regression: pass");
      end else begin
         $display("max_empty_rectangle_area regression: fail");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mera_pkg.sv
hw/rtl/mera_ram.sv
hw/rtl/max_empty_rectangle_area.sv
dv/tb_max_empty_rectangle_area.sv
